@@ rtl/core/trig_palette_color_generator_core_macros.svh @@
// Assertion macros shared by the palette color generator RTL
`ifndef TRIG_PALETTE_COLOR_GENERATOR_CORE_MACROS_SVH
`define TRIG_PALETTE_COLOR_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TPCG_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("tpcg assertion failed");

// Next-cycle implication, checked outside reset
`define TPCG_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("tpcg assertion failed");

`endif

@@ rtl/core/tpcg_pkg.sv @@
// Shared types and constants of the palette color generator
package tpcg_pkg;

  // Palette and register layout
  localparam int unsigned PALETTE_SIZE = 256;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd1;
  localparam logic [7:0] CLASS_COUNT_RST = 8'd255;

  // Phase in units of pi/65536
  localparam int unsigned QUOT_W      = 17;
  localparam int unsigned DIVIDEND_W  = 25;
  localparam logic [16:0] HALF_TURN    = 17'd65536;
  localparam logic [16:0] QUARTER_TURN = 17'd32768;

  // pi * 2^45, rounded from pi * 2^48
  localparam logic [63:0] PI_Q48 = 64'h3243F6A8885A3;
  localparam logic [46:0] PI_Q45 = 47'((PI_Q48 + 64'd4) >> 3);

  // Pipeline geometry: input register, divider, fold register, sine, output register
  localparam int unsigned DIV_STAGES = 5;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned SIN_TERMS  = 7;
  localparam int unsigned SIN_LAT    = 2 + 3 * SIN_TERMS + 1;
  localparam int unsigned PIPE_LAST  = 1 + DIV_STAGES + 1 + SIN_LAT;
  localparam int unsigned PHASE_POS  = DIV_STAGES + 1;

  typedef enum logic [1:0] {
    MODE_BLUE_RED   = 2'd0,
    MODE_BLUE_GREEN = 2'd1,
    MODE_RED_GREEN  = 2'd2
  } map_mode_t;

  // Control bits that travel alongside the data
  typedef struct packed {
    logic vld;
    logic blk;
    logic neg;
  } side_t;

endpackage

@@ rtl/core/tpcg_div.sv @@
// Pipelined restoring divider that forms the phase quotient
module tpcg_div import tpcg_pkg::*; (
  input  logic                  clk,
  input  logic                  ce,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [7:0]            divisor,
  output logic [QUOT_W-1:0]     quotient
);

  logic [7:0]        rem_r [0:DIV_STAGES-1];
  logic [QUOT_W-1:0] num_r [0:DIV_STAGES-1];
  logic [QUOT_W-1:0] quo_r [0:DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [7:0]        rem_in;
    logic [QUOT_W-1:0] num_in;
    logic [QUOT_W-1:0] quo_in;
    logic [7:0]        rem_nxt;
    logic [QUOT_W-1:0] num_nxt;
    logic [QUOT_W-1:0] quo_nxt;

    // Stage input: dividend for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign rem_in = dividend[DIVIDEND_W-1:QUOT_W];
      assign num_in = dividend[QUOT_W-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // Up to four quotient bits per stage
    always_comb begin
      logic [8:0] t;
      rem_nxt = rem_in;
      num_nxt = num_in;
      quo_nxt = quo_in;
      t       = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (k * DIV_STEPS + j < QUOT_W) begin
          t = {rem_nxt, num_nxt[QUOT_W-1]};
          num_nxt = {num_nxt[QUOT_W-2:0], 1'b0};
          if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
            quo_nxt = {quo_nxt[QUOT_W-2:0], 1'b1};
          end else begin
            quo_nxt = {quo_nxt[QUOT_W-2:0], 1'b0};
          end
          rem_nxt = t[7:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= num_nxt;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quotient = quo_r[DIV_STAGES-1];

endmodule

@@ rtl/core/tpcg_sine.sv @@
// Pipelined fixed-point quarter-wave sine, Taylor series through x^15
module tpcg_sine import tpcg_pkg::*; (
  input  logic        clk,
  input  logic        ce,
  input  logic [15:0] q,
  output logic [15:0] level
);

  logic [30:0]        x_r;
  logic [31:0]        x2_r   [0:SIN_TERMS];
  logic [31:0]        x2a_r  [1:SIN_TERMS];
  logic [31:0]        x2b_r  [1:SIN_TERMS];
  logic [30:0]        term_r [0:SIN_TERMS];
  logic signed [32:0] sum_r  [0:SIN_TERMS];
  logic signed [32:0] suma_r [1:SIN_TERMS];
  logic signed [32:0] sumb_r [1:SIN_TERMS];
  logic [62:0]        prod_r [1:SIN_TERMS];
  logic [64:0]        mq_r   [1:SIN_TERMS];
  logic [15:0]        level_r;

  // Angle in Q30 from the quarter-wave phase
  logic [63:0] ang;
  assign ang = 64'(q) * 64'(PI_Q45) + (64'd1 << 30);

  // Square of the angle, series seed
  logic [61:0] sq;
  assign sq = 62'(x_r) * 62'(x_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r       <= ang[61:31];
      x2_r[0]   <= sq[61:30];
      term_r[0] <= x_r;
      sum_r[0]  <= $signed({2'b00, x_r});
    end
  end

  // One term per three stages: multiply, scale by reciprocal, accumulate
  for (genvar n = 1; n <= SIN_TERMS; n++) begin : g_term
    localparam int unsigned DIV = 2 * n * (2 * n + 1);
    localparam int unsigned SH  = $clog2(DIV);
    localparam logic [63:0] RECIP = ((64'd1 << (32 + SH)) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [30:0] term_nxt;
    assign term_nxt = 31'(mq_r[n] >> (32 + SH));

    always_ff @(posedge clk) begin
      if (ce) begin
        prod_r[n] <= 63'(term_r[n-1]) * 63'(x2_r[n-1]);
        x2a_r[n]  <= x2_r[n-1];
        suma_r[n] <= sum_r[n-1];

        mq_r[n]   <= 65'(prod_r[n][61:30]) * 65'(RECIP[32:0]);
        x2b_r[n]  <= x2a_r[n];
        sumb_r[n] <= suma_r[n];

        term_r[n] <= term_nxt;
        x2_r[n]   <= x2b_r[n];
        if (n % 2 == 1) begin
          sum_r[n] <= sumb_r[n] - $signed({2'b00, term_nxt});
        end else begin
          sum_r[n] <= sumb_r[n] + $signed({2'b00, term_nxt});
        end
      end
    end
  end

  // Scale to 0..65535 with rounding, clip both ends
  logic [31:0] s_pos;
  logic [48:0] lev_full;
  logic [18:0] lev;
  assign s_pos    = sum_r[SIN_TERMS][32] ? 32'd0 : sum_r[SIN_TERMS][31:0];
  assign lev_full = ({17'd0, s_pos} << 16) - {17'd0, s_pos} + (49'd1 << 29);
  assign lev      = lev_full[48:30];

  always_ff @(posedge clk) begin
    if (ce) begin
      level_r <= (lev > 19'd65535) ? 16'hFFFF : lev[15:0];
    end
  end

  assign level = level_r;

endmodule

@@ rtl/core/trig_palette_color_generator_core.sv @@
// Pipeline: 32 register stages; an accepted index passes the input register, divider,
// fold register and sine to the output register. Throughput: one transaction per cycle;
// the divider and sine pipelines take a new index every cycle and the whole pipe
// freezes while a held result is stalled.
// Reset (synchronous, rst_n low) clears all valid bits, map_mode to 0 and
// class_count to 255; no clearing pass.
module trig_palette_color_generator_core import tpcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_class_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_red_level,
  output logic [15:0]           out_green_level,
  output logic [15:0]           out_blue_level,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "trig_palette_color_generator_core_macros.svh"

  map_mode_t   map_mode_r;
  logic [7:0]  class_count_r;
  side_t       line_r [0:PIPE_LAST];
  logic        ce;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r    <= MODE_BLUE_RED;
      class_count_r <= CLASS_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_MODE:    map_mode_r    <= map_mode_t'(cfg_data[1:0]);
        CFG_CLASS_COUNT: class_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances unless a finished result is held
  assign ce       = !(line_r[PIPE_LAST].vld && out_stall);
  assign in_stall = !ce;

  // Input stage: dividend and black test
  logic                  blk_in;
  logic [DIVIDEND_W-1:0] dvd_r;
  assign blk_in = (in_class_index == 8'd0) || (class_count_r == 8'd0) ||
                  (in_class_index > class_count_r) ||
                  (32'(in_class_index) >= PALETTE_SIZE);

  always_ff @(posedge clk) begin
    if (ce) begin
      dvd_r <= {1'b0, in_class_index, 9'd0, class_count_r[7:1]};
    end
  end

  logic [QUOT_W-1:0] phase;
  tpcg_div u_div (
    .clk      (clk),
    .ce       (ce),
    .dividend (dvd_r),
    .divisor  (class_count_r),
    .quotient (phase)
  );

  // Fold phase into the quarter wave for sin and cos
  logic        neg;
  logic [15:0] qs_r;
  logic [15:0] qc_r;
  logic [16:0] qs_full;
  logic [16:0] qc_full;
  assign neg     = phase > QUARTER_TURN;
  assign qs_full = neg ? (HALF_TURN - phase) : phase;
  assign qc_full = neg ? (phase - QUARTER_TURN) : (QUARTER_TURN - phase);

  always_ff @(posedge clk) begin
    if (ce) begin
      qs_r <= qs_full[15:0];
      qc_r <= qc_full[15:0];
    end
  end

  logic [15:0] sn_lvl;
  logic [15:0] cs_lvl;
  tpcg_sine u_sin (.clk(clk), .ce(ce), .q(qs_r), .level(sn_lvl));
  tpcg_sine u_cos (.clk(clk), .ce(ce), .q(qc_r), .level(cs_lvl));

  // Side-band line: valid, black and cosine sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= PIPE_LAST; i++) begin
        line_r[i] <= '0;
      end
    end else if (ce) begin
      line_r[0] <= '{vld: in_valid, blk: blk_in, neg: 1'b0};
      for (int i = 1; i <= PIPE_LAST; i++) begin
        if (i == PHASE_POS) begin
          line_r[i] <= '{vld: line_r[i-1].vld, blk: line_r[i-1].blk, neg: neg};
        end else begin
          line_r[i] <= line_r[i-1];
        end
      end
    end
  end

  // Channel mapping and output register
  side_t       last_s;
  logic [15:0] cpos;
  logic [15:0] cneg;
  logic [15:0] red_nxt;
  logic [15:0] green_nxt;
  logic [15:0] blue_nxt;
  logic [15:0] red_r;
  logic [15:0] green_r;
  logic [15:0] blue_r;
  assign last_s = line_r[PIPE_LAST-1];
  assign cpos   = last_s.neg ? 16'd0 : cs_lvl;
  assign cneg   = last_s.neg ? cs_lvl : 16'd0;

  always_comb begin
    case (map_mode_r)
      MODE_BLUE_GREEN: begin
        red_nxt = sn_lvl; green_nxt = cneg; blue_nxt = cpos;
      end
      MODE_RED_GREEN: begin
        red_nxt = cpos; green_nxt = cneg; blue_nxt = sn_lvl;
      end
      default: begin
        red_nxt = cneg; green_nxt = sn_lvl; blue_nxt = cpos;
      end
    endcase
    if (last_s.blk) begin
      red_nxt = 16'd0; green_nxt = 16'd0; blue_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid       = line_r[PIPE_LAST].vld;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

  // Checks
  `TPCG_ASSERT_NOW(a_black_zero, clk, rst_n,
    line_r[PIPE_LAST].vld && line_r[PIPE_LAST].blk,
    out_red_level == 16'd0 && out_green_level == 16'd0 && out_blue_level == 16'd0)
  `TPCG_ASSERT_NOW(a_neg_no_blue, clk, rst_n,
    out_valid && line_r[PIPE_LAST].neg && map_mode_r == MODE_BLUE_RED,
    out_blue_level == 16'd0)
  `TPCG_ASSERT_NEXT(a_hold_pipe, clk, rst_n,
    out_valid && out_stall,
    $stable(line_r[PHASE_POS]) && $stable(qs_r))

endmodule
